// ----- rtl/core/vna_pkg.sv -----
// Package for the vertex normal accumulator: sizes, item codes, controller/datapath
// command and status types. No dependencies.
`default_nettype none
package vna_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W = 10;
    localparam int SUM_WIDTH = 24;
    localparam int POS_W = 32;
    localparam int Q_W = 16;
    localparam int EDGE_TOP_BIT = 23;
    localparam int NORM_TOP_BIT = 29;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_STORE = 2'd1,
        KIND_TRI   = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // one step of work per opcode; the datapath runs each to completion
    typedef enum logic [3:0] {
        OP_NONE, OP_CLR, OP_RDA, OP_RDB, OP_RDC, OP_EDGE, OP_SCALE, OP_CROSS1, OP_CROSS2,
        OP_NSCALE, OP_SQ, OP_SQRT, OP_DIV, OP_ACC, OP_RDS, OP_OUT
    } op_t;

    typedef struct packed {
        logic  go;
        op_t   op;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic skip;
    } sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/vna_ctrl.sv -----
// Controller for the vertex normal accumulator: sequences datapath operations.
// Depends on vna_pkg.
`default_nettype none
module vna_ctrl
    import vna_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] kind,
    output logic            busy,
    output cmd_t            cmd,
    input  sts_t            sts
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] sel_reg, sel_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        sel_next   = sel_reg;
        cmd.go     = 1'b0;
        cmd.op     = op_reg;
        cmd.sel    = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    k_next     = kind;
                    sel_next   = 2'd0;
                    state_next = S_RUN;
                    case (kind_t'(kind))
                        KIND_CLEAR: op_next = OP_CLR;
                        KIND_STORE: op_next = OP_NONE;
                        KIND_TRI:   op_next = OP_RDA;
                        default:    op_next = OP_RDS;
                    endcase
                end
            end
            S_RUN:
            begin
                cmd.go     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.done)
                begin
                    state_next = S_RUN;
                    if (sts.skip)
                    begin
                        state_next = (k_reg == KIND_READ) ? S_RUN : S_IDLE;
                        op_next    = OP_OUT;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_RDA:    op_next = OP_RDB;
                            OP_RDB:    op_next = OP_RDC;
                            OP_RDC:    op_next = OP_EDGE;
                            OP_EDGE:   op_next = OP_SCALE;
                            OP_SCALE:  op_next = OP_CROSS1;
                            OP_CROSS1: op_next = OP_CROSS2;
                            OP_CROSS2: op_next = OP_NSCALE;
                            OP_RDS:    op_next = OP_NSCALE;
                            OP_NSCALE: op_next = OP_SQ;
                            OP_SQ:     op_next = OP_SQRT;
                            OP_SQRT:   op_next = OP_DIV;
                            OP_DIV:    op_next = (k_reg == KIND_READ) ? OP_OUT : OP_ACC;
                            OP_ACC:
                            begin
                                if (sel_reg == 2'd2)
                                    state_next = S_IDLE;
                                else
                                    sel_next = sel_reg + 2'd1;
                            end
                            default:   state_next = S_IDLE;
                        endcase
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // reset starts a clearing pass over the sum memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            op_reg    <= OP_CLR;
            k_reg     <= 2'd0;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            sel_reg   <= sel_next;
        end
    end

    a_go_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |=> !cmd.go)
        else $error("go held two cycles");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg != 2'd3)
        else $error("corner select out of range");
endmodule
`default_nettype wire

// ----- rtl/core/vna_datapath.sv -----
// Datapath of the vertex normal accumulator: vertex and sum memories, edge and cross
// product, block scaling, iterative square root and divider. Depends on vna_pkg.
`default_nettype none
module vna_datapath
    import vna_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [1:0]        kind,
    input  wire logic [IDX_W-1:0]  vertex_index,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    input  wire logic [IDX_W-1:0]  corner_first,
    input  wire logic [IDX_W-1:0]  corner_second,
    input  wire logic [IDX_W-1:0]  corner_third,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic signed [Q_W-1:0]  normal_x,
    output logic signed [Q_W-1:0]  normal_y,
    output logic signed [Q_W-1:0]  normal_z,
    output logic                   zero_normal,
    output logic                   saturated,
    output logic                   result_valid
);
    localparam int SW = 3 * SUM_WIDTH;

    logic [3*POS_W-1:0] vmem [MAX_VERTICES];
    logic [SW:0]        smem [MAX_VERTICES];   // {saturation mark, x, y, z sums}

    logic [IDX_W-1:0] ca_reg, cb_reg, cc_reg, vi_reg;
    logic [IDX_W-1:0] clr_reg;
    logic [3*POS_W-1:0] vrd_reg;
    logic [SW:0]        srd_reg;
    logic signed [POS_W-1:0] pa_reg [3];
    logic signed [POS_W-1:0] pb_reg [3];
    logic signed [63:0] v_reg [3];   // working vector
    logic signed [63:0] e0_reg [3];
    logic signed [63:0] e1_reg [3];
    logic [63:0] sum_reg, rem_reg, root_reg, bit_reg;
    logic [1:0]  ci_reg;             // component index for serial steps
    logic        busyop_reg, done_reg, skip_reg;
    logic        sat_reg;
    logic [Q_W-1:0] q_reg [3];
    logic [47:0] num_reg, dr_reg;
    logic [30:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic [1:0]  phase_reg;

    // block scale helper: returns the magnitude of a signed value
    function automatic logic [63:0] mag(input logic signed [63:0] v);
        mag = v[63] ? 64'(-v) : v;
    endfunction

    function automatic logic [5:0] msb(input logic [63:0] m);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++)
            if (m[i])
                p = 6'(i);
        msb = p;
    endfunction

    function automatic logic [IDX_W-1:0] corner_sel(input logic [1:0] s);
        corner_sel = (s == 2'd0) ? ca_reg : (s == 2'd1) ? cb_reg : cc_reg;
    endfunction

    logic [63:0] bigm;
    logic [5:0]  bigp;
    always_comb
    begin
        bigm = mag(v_reg[0]) | mag(v_reg[1]) | mag(v_reg[2]);
        bigp = msb(bigm);
    end

    function automatic logic signed [63:0] scl(input logic signed [63:0] v,
                                               input logic [5:0] p, input logic [5:0] t);
        logic [63:0] m, s;
        m = mag(v);
        s = (p > t) ? (m >> (p - t)) : (m << (t - p));
        scl = v[63] ? -$signed(s) : $signed(s);
    endfunction

    logic [63:0] cur_mag;
    logic [63:0] sq_prod;
    assign cur_mag = mag(v_reg[ci_reg]);
    assign sq_prod = cur_mag[31:0] * cur_mag[31:0];

    // scaled edges fit 25 signed bits, so the cross terms use a 25x25 multiplier
    logic [1:0] ci_p1, ci_p2;
    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] cross_prod;
    always_comb
    begin
        case (ci_reg)
            2'd0:
            begin
                ci_p1 = 2'd1;
                ci_p2 = 2'd2;
            end
            2'd1:
            begin
                ci_p1 = 2'd2;
                ci_p2 = 2'd0;
            end
            default:
            begin
                ci_p1 = 2'd0;
                ci_p2 = 2'd1;
            end
        endcase
        if (cmd.op == OP_CROSS1)
        begin
            mul_a = $signed(e0_reg[ci_p1][24:0]);
            mul_b = $signed(e1_reg[ci_p2][24:0]);
        end
        else
        begin
            mul_a = $signed(e0_reg[ci_p2][24:0]);
            mul_b = $signed(e1_reg[ci_p1][24:0]);
        end
        cross_prod = mul_a * mul_b;
    end

    logic [SUM_WIDTH-1:0] sc [3];
    logic signed [SUM_WIDTH+1:0] ns;
    logic [SUM_WIDTH-1:0] hi_c, lo_c;
    assign hi_c = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    assign lo_c = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic [IDX_W-1:0] acc_idx;
    always_comb
    begin
        case (cmd.sel)
            2'd0:    acc_idx = ca_reg;
            2'd1:    acc_idx = cb_reg;
            default: acc_idx = cc_reg;
        endcase
    end

    assign sts.done = done_reg;
    assign sts.skip = skip_reg;

    logic [SW-1:0] sum_word;
    assign sum_word = srd_reg[SW-1:0];

    logic any_sat;
    logic new_mark;
    assign new_mark = srd_reg[SW] | any_sat;

    always_ff @(posedge clk)
    begin
        if (start && !busy && kind == KIND_STORE)
            vmem[vertex_index] <= {pos_x, pos_y, pos_z};
        if (cmd.go)
            vrd_reg <= vmem[(cmd.op == OP_RDA) ? corner_sel(2'd0)
                          : (cmd.op == OP_RDB) ? corner_sel(2'd1) : corner_sel(2'd2)];
        srd_reg <= smem[(busyop_reg && cmd.op == OP_RDS) ? vi_reg : acc_idx];
        if (busyop_reg && cmd.op == OP_CLR)
            smem[clr_reg] <= '0;
        else if (busyop_reg && cmd.op == OP_ACC && phase_reg == 2'd2)
            smem[acc_idx] <= {new_mark, sc[0], sc[1], sc[2]};
    end

    always_comb
    begin
        any_sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ns = $signed({{2{sum_word[SW-1-i*SUM_WIDTH]}},
                          sum_word[SW-1-i*SUM_WIDTH -: SUM_WIDTH]})
                 + (SUM_WIDTH+2)'($signed(q_reg[i]));
            if (ns > $signed({2'b00, hi_c}))
            begin
                sc[i] = hi_c;
                any_sat = 1'b1;
            end
            else if (ns < $signed({2'b11, lo_c}))
            begin
                sc[i] = lo_c;
                any_sat = 1'b1;
            end
            else
                sc[i] = ns[SUM_WIDTH-1:0];
        end
    end

    logic [63:0] tryv;
    assign tryv = root_reg + bit_reg;
    logic [47:0] dsub;
    assign dsub = num_reg - dr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busyop_reg   <= 1'b0;
            done_reg     <= 1'b0;
            skip_reg     <= 1'b0;
            result_valid <= 1'b0;
            phase_reg    <= 2'd0;
            ci_reg       <= 2'd0;
            clr_reg      <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            skip_reg     <= 1'b0;
            result_valid <= 1'b0;
            if (start && !busy)
            begin
                ca_reg <= corner_first;
                cb_reg <= corner_second;
                cc_reg <= corner_third;
                vi_reg <= vertex_index;
            end
            if (cmd.go)
            begin
                busyop_reg <= 1'b1;
                phase_reg  <= 2'd0;
                ci_reg     <= 2'd0;
                clr_reg    <= '0;
            end
            else if (busyop_reg && !done_reg)
            begin
                case (cmd.op)
                    OP_CLR:
                    begin
                        // one sum entry cleared per cycle
                        if (clr_reg == IDX_W'(MAX_VERTICES - 1))
                        begin
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                        else
                            clr_reg <= clr_reg + IDX_W'(1);
                    end
                    OP_RDA, OP_RDB, OP_RDC:
                    begin
                        if (cmd.op == OP_RDA)
                        begin
                            pa_reg[0] <= vrd_reg[95:64];
                            pa_reg[1] <= vrd_reg[63:32];
                            pa_reg[2] <= vrd_reg[31:0];
                        end
                        else if (cmd.op == OP_RDB)
                        begin
                            pb_reg[0] <= vrd_reg[95:64];
                            pb_reg[1] <= vrd_reg[63:32];
                            pb_reg[2] <= vrd_reg[31:0];
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                e0_reg[i] <= 64'($signed(vrd_reg[95-32*i -: 32]))
                                             - 64'(pa_reg[i]);
                                e1_reg[i] <= 64'($signed(vrd_reg[95-32*i -: 32]))
                                             - 64'(pb_reg[i]);
                            end
                        end
                        done_reg   <= 1'b1;
                        busyop_reg <= 1'b0;
                    end
                    OP_EDGE:
                    begin
                        v_reg      <= e0_reg;
                        done_reg   <= 1'b1;
                        busyop_reg <= 1'b0;
                    end
                    OP_SCALE:
                    begin
                        // phase 0 scales e0 (in v), phase 1 scales e1
                        if (bigm == 64'd0)
                        begin
                            done_reg   <= 1'b1;
                            skip_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                        else if (phase_reg == 2'd0)
                        begin
                            for (int i = 0; i < 3; i++)
                                e0_reg[i] <= scl(v_reg[i], bigp, 6'(EDGE_TOP_BIT));
                            v_reg     <= e1_reg;
                            phase_reg <= 2'd1;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                e1_reg[i] <= scl(v_reg[i], bigp, 6'(EDGE_TOP_BIT));
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                    end
                    OP_CROSS1, OP_CROSS2:
                    begin
                        // one product per cycle: op1 forms first terms, op2 subtracts
                        if (cmd.op == OP_CROSS1)
                            v_reg[ci_reg] <= 64'(cross_prod);
                        else
                            v_reg[ci_reg] <= v_reg[ci_reg] - 64'(cross_prod);
                        if (ci_reg == 2'd2)
                        begin
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                        else
                            ci_reg <= ci_reg + 2'd1;
                    end
                    OP_RDS:
                    begin
                        if (phase_reg == 2'd0)
                            phase_reg <= 2'd1;  // sum memory read latency
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                v_reg[i] <= 64'($signed(srd_reg[SW-1-i*SUM_WIDTH -: SUM_WIDTH]));
                            sat_reg    <= srd_reg[SW];
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                    end
                    OP_NSCALE:
                    begin
                        if (bigm == 64'd0)
                        begin
                            for (int i = 0; i < 3; i++)
                                q_reg[i] <= '0;
                            done_reg   <= 1'b1;
                            skip_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                v_reg[i] <= scl(v_reg[i], bigp, 6'(NORM_TOP_BIT));
                            sum_reg    <= '0;
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                    end
                    OP_SQ:
                    begin
                        sum_reg <= sum_reg + sq_prod;
                        if (ci_reg == 2'd2)
                        begin
                            rem_reg    <= '0;
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                            root_reg   <= '0;
                            bit_reg    <= 64'd1 << 62;
                        end
                        else
                            ci_reg <= ci_reg + 2'd1;
                    end
                    OP_SQRT:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            rem_reg   <= sum_reg;
                            phase_reg <= 2'd1;
                        end
                        else if (bit_reg == 64'd0)
                        begin
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                        else
                        begin
                            if (rem_reg >= tryv)
                            begin
                                rem_reg  <= rem_reg - tryv;
                                root_reg <= (root_reg >> 1) + bit_reg;
                            end
                            else
                                root_reg <= root_reg >> 1;
                            bit_reg <= bit_reg >> 2;
                        end
                    end
                    OP_DIV:
                    begin
                        // restoring divide, one quotient bit a cycle, per component;
                        // the quotient never exceeds 16384, so 16 bits suffice
                        if (phase_reg == 2'd0)
                        begin
                            num_reg   <= 48'(cur_mag[31:0]) * 48'd16384
                                         + 48'(root_reg[32:1]);
                            dr_reg    <= 48'(root_reg[31:0]) << 15;
                            quo_reg   <= '0;
                            dcnt_reg  <= 6'd16;
                            phase_reg <= 2'd1;
                        end
                        else if (dcnt_reg != 6'd0)
                        begin
                            if (num_reg >= dr_reg)
                            begin
                                num_reg <= dsub;
                                quo_reg <= {quo_reg[29:0], 1'b1};
                            end
                            else
                                quo_reg <= {quo_reg[29:0], 1'b0};
                            dr_reg   <= dr_reg >> 1;
                            dcnt_reg <= dcnt_reg - 6'd1;
                        end
                        else
                        begin
                            q_reg[ci_reg] <= v_reg[ci_reg][63] ? Q_W'(-quo_reg[15:0])
                                                                 : quo_reg[15:0];
                            phase_reg <= 2'd0;
                            if (ci_reg == 2'd2)
                            begin
                                done_reg   <= 1'b1;
                                busyop_reg <= 1'b0;
                            end
                            else
                                ci_reg <= ci_reg + 2'd1;
                        end
                    end
                    OP_ACC:
                    begin
                        // phase 0/1: read sum memory, 2: write back
                        if (phase_reg != 2'd2)
                            phase_reg <= phase_reg + 2'd1;
                        else
                        begin
                            done_reg   <= 1'b1;
                            busyop_reg <= 1'b0;
                        end
                    end
                    OP_OUT:
                    begin
                        normal_x     <= q_reg[0];
                        normal_y     <= q_reg[1];
                        normal_z     <= q_reg[2];
                        zero_normal  <= (q_reg[0] == '0) && (q_reg[1] == '0)
                                        && (q_reg[2] == '0);
                        saturated    <= sat_reg;
                        result_valid <= 1'b1;
                        done_reg     <= 1'b1;
                        busyop_reg   <= 1'b0;
                    end
                    default:
                    begin
                        done_reg   <= 1'b1;
                        busyop_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held");
    a_skip_done: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> done_reg)
        else $error("skip without done");
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result repeated");
endmodule
`default_nettype wire

// ----- rtl/core/vertex_normal_accumulator_unit.sv -----
// Vertex normal accumulator top level: joins controller and datapath.
// Depends on vna_pkg, vna_ctrl, vna_datapath.
//
// Items are taken while busy is low. Right after reset the block clears the sum
// memory one entry a cycle, with busy high until the clear is done; a clear
// transaction clears it the same way. The length of a triangle or a read is set by
// the bit-serial square root and the per-component restoring divider; degenerate
// faces and zero reads finish early. A read result appears with strobe high for one
// cycle, the last busy cycle; the receiver cannot stall it.
`default_nettype none
module vertex_normal_accumulator_unit
    import vna_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              kind,
    input  wire logic [IDX_W-1:0]        vertex_index,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    input  wire logic [IDX_W-1:0]        corner_first,
    input  wire logic [IDX_W-1:0]        corner_second,
    input  wire logic [IDX_W-1:0]        corner_third,
    output logic                         strobe,
    output logic signed [Q_W-1:0]        normal_x,
    output logic signed [Q_W-1:0]        normal_y,
    output logic signed [Q_W-1:0]        normal_z,
    output logic                         zero_normal,
    output logic                         saturated
);
    cmd_t cmd;
    sts_t sts;

    vna_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    vna_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .vertex_index  (vertex_index),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .corner_first  (corner_first),
        .corner_second (corner_second),
        .corner_third  (corner_third),
        .cmd           (cmd),
        .sts           (sts),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .zero_normal   (zero_normal),
        .saturated     (saturated),
        .result_valid  (strobe)
    );
endmodule
`default_nettype wire
